/* rtl/core/lvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU victim select package
// Shared sizes, request and register codes, and the types passed between the
// rank store, the victim picker and the top level.
// ----------------------------------------------------------------------------
package lvs_pkg;

  // Set geometry.
  localparam int WAYS   = 8;
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W  = RANK_W;

  // Fixed field widths of the request and result.
  localparam int MASK_W    = 8;
  localparam int TOUCH_W   = 3;
  localparam int OUT_WAY_W = 3;
  localparam int THR_W     = 4;
  localparam int SET_W     = 10;
  localparam int CNT_W     = $clog2(MASK_W + 1);

  // Configuration reset values.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);
  localparam logic [SET_W-1:0] SET_RESET = '0;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [WAYS-1:0][RANK_W-1:0] rank_vec_t;

  // Request kinds.
  typedef enum logic {
    REQ_TOUCH  = 1'b0,
    REQ_VICTIM = 1'b1
  } req_kind_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_DIRTY_THRESHOLD = 1'b0,
    CFG_SET_ID          = 1'b1
  } cfg_idx_t;

  // Move-to-MRU command for the rank store.
  typedef struct packed {
    logic en;
    way_t way;
  } mru_upd_t;

  // One result.
  typedef struct packed {
    logic [OUT_WAY_W-1:0] victim_way;
    logic                 checkpoint_request;
    logic [SET_W-1:0]     checkpoint_set;
    logic                 took_invalid;
  } result_t;

  // Bit i of a request mask; ways past the mask width read as zero.
  function automatic logic mask_bit(logic [MASK_W-1:0] m, int unsigned i);
    logic b;
    b = 1'b0;
    for (int k = 0; k < MASK_W; k++) begin
      if (k == i) begin
        b = m[k];
      end
    end
    return b;
  endfunction

endpackage

/* rtl/core/lvs_rank_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU rank store
// Holds the true-LRU rank of every way and applies one move-to-MRU per cycle.
// ----------------------------------------------------------------------------
module lvs_rank_store (
  input  logic               clk,
  input  logic               rst,
  input  lvs_pkg::mru_upd_t  upd,
  output lvs_pkg::rank_vec_t ranks
);
  import lvs_pkg::*;

  rank_vec_t ranks_next;
  rank_t     sel_rank;

  // Ways younger than the touched way age by one; the touched way becomes MRU.
  always_comb begin
    sel_rank   = ranks[upd.way];
    ranks_next = ranks;
    if (upd.en) begin
      for (int j = 0; j < WAYS; j++) begin
        if (WAY_W'(j) == upd.way) begin
          ranks_next[j] = '0;
        end else if (ranks[j] < sel_rank) begin
          ranks_next[j] = ranks[j] + 1'b1;
        end
      end
    end
  end

  // Rank registers; after reset way i holds rank i.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WAYS; j++) begin
        ranks[j] <= RANK_W'(j);
      end
    end else begin
      ranks <= ranks_next;
    end
  end

endmodule

/* rtl/core/lvs_victim_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU victim picker
// Decides the victim for a registered request from the current ranks and
// produces the result and the rank update.
// ----------------------------------------------------------------------------
module lvs_victim_pick (
  input  logic                         req_valid,
  input  lvs_pkg::req_kind_t           req_type,
  input  logic [lvs_pkg::TOUCH_W-1:0]  touch_way,
  input  logic [lvs_pkg::MASK_W-1:0]   valid_mask,
  input  logic [lvs_pkg::MASK_W-1:0]   dirty_mask,
  input  logic [lvs_pkg::MASK_W-1:0]   replaceable_mask,
  input  lvs_pkg::rank_vec_t           ranks,
  input  logic [lvs_pkg::THR_W-1:0]    dirty_threshold,
  input  logic [lvs_pkg::SET_W-1:0]    set_id,
  output lvs_pkg::mru_upd_t            upd,
  output logic                         emit,
  output lvs_pkg::result_t             res
);
  import lvs_pkg::*;

  logic             inv_found;
  way_t             inv_way;
  logic [CNT_W-1:0] dirty_cnt;
  way_t             best_way;
  rank_t            best_rank;
  way_t             lru_way;
  logic             ckpt;

  // Lowest invalid way, dirty count, best replaceable way and the LRU way.
  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!mask_bit(valid_mask, i)) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end

    dirty_cnt = '0;
    for (int i = 0; i < WAYS; i++) begin
      dirty_cnt = dirty_cnt + CNT_W'(mask_bit(dirty_mask, i));
    end

    best_way  = '0;
    best_rank = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (ranks[i] > best_rank && mask_bit(replaceable_mask, i)) begin
        best_way  = WAY_W'(i);
        best_rank = ranks[i];
      end
    end

    lru_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (ranks[i] == RANK_W'(WAYS - 1)) begin
        lru_way = WAY_W'(i);
      end
    end
  end

  assign ckpt = !inv_found && (dirty_cnt >= CNT_W'(dirty_threshold));

  // Result and rank update for the request kind.
  always_comb begin
    upd     = '0;
    emit    = 1'b0;
    res     = '0;
    unique case (req_type)
      REQ_TOUCH: begin
        upd.en  = req_valid && (32'(touch_way) < WAYS);
        upd.way = WAY_W'(touch_way);
      end
      REQ_VICTIM: begin
        emit = req_valid;
        if (inv_found) begin
          upd.en           = req_valid;
          upd.way          = inv_way;
          res.victim_way   = OUT_WAY_W'(inv_way);
          res.took_invalid = 1'b1;
        end else if (ckpt) begin
          // Checkpoint eviction leaves the ranks alone.
          res.victim_way         = OUT_WAY_W'(lru_way);
          res.checkpoint_request = 1'b1;
          res.checkpoint_set     = set_id;
        end else begin
          upd.en         = req_valid;
          upd.way        = best_way;
          res.victim_way = OUT_WAY_W'(best_way);
        end
      end
      default: begin
        upd = '0;
      end
    endcase
  end

endmodule

/* rtl/core/lru_victim_select_dirty_threshold.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU victim select with dirty threshold
// True-LRU replacement for one cache set, with a checkpoint eviction path
// taken when no way is invalid and enough ways are dirty.
// ----------------------------------------------------------------------------
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+-----------------
//  request   | req_type touch_way valid_mask dirty_mask            | start && !busy
//            | replaceable_mask                                   |
//  result    | victim_way checkpoint_request checkpoint_set        | result_strobe
//            | took_invalid                                       |
//  config    | cfg_wr_en cfg_index cfg_wdata                      | cfg_wr_en
//
//  One request is accepted every cycle while busy is low. A victim request
//  passes the request register and then the result register, where its
//  strobe marks the result. The rank registers update together with the
//  result register, so the next request already sees the new order. A touch
//  gives no result.
//  busy is high only during reset and the cycle after it. The receiver cannot
//  stall; each result stands for exactly one cycle.
// ----------------------------------------------------------------------------
module lru_victim_select_dirty_threshold (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [lvs_pkg::TOUCH_W-1:0]    touch_way,
  input  logic [lvs_pkg::MASK_W-1:0]     valid_mask,
  input  logic [lvs_pkg::MASK_W-1:0]     dirty_mask,
  input  logic [lvs_pkg::MASK_W-1:0]     replaceable_mask,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [lvs_pkg::SET_W-1:0]      cfg_wdata,
  output logic                           result_strobe,
  output logic [lvs_pkg::OUT_WAY_W-1:0]  victim_way,
  output logic                           checkpoint_request,
  output logic [lvs_pkg::SET_W-1:0]      checkpoint_set,
  output logic                           took_invalid
);
  import lvs_pkg::*;

  logic               boot;
  logic               accept;
  logic [THR_W-1:0]   dirty_threshold;
  logic [SET_W-1:0]   set_id;

  logic               s1_valid;
  req_kind_t          s1_req_type;
  logic [TOUCH_W-1:0] s1_touch_way;
  logic [MASK_W-1:0]  s1_valid_mask;
  logic [MASK_W-1:0]  s1_dirty_mask;
  logic [MASK_W-1:0]  s1_replaceable_mask;

  rank_vec_t          ranks;
  mru_upd_t           upd;
  logic               emit;
  result_t            res;

  // Hold requests off during reset and in the cycle after it.
  always_ff @(posedge clk) begin
    boot <= rst;
  end

  assign busy   = rst | boot;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_threshold <= THR_RESET;
      set_id          <= SET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIRTY_THRESHOLD: dirty_threshold <= cfg_wdata[THR_W-1:0];
        CFG_SET_ID:          set_id          <= cfg_wdata;
        default:             set_id          <= set_id;
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_type         <= req_kind_t'(req_type);
      s1_touch_way        <= touch_way;
      s1_valid_mask       <= valid_mask;
      s1_dirty_mask       <= dirty_mask;
      s1_replaceable_mask <= replaceable_mask;
    end
  end

  // Victim decision on the registered request.
  lvs_victim_pick u_pick (
    .req_valid        (s1_valid),
    .req_type         (s1_req_type),
    .touch_way        (s1_touch_way),
    .valid_mask       (s1_valid_mask),
    .dirty_mask       (s1_dirty_mask),
    .replaceable_mask (s1_replaceable_mask),
    .ranks            (ranks),
    .dirty_threshold  (dirty_threshold),
    .set_id           (set_id),
    .upd              (upd),
    .emit             (emit),
    .res              (res)
  );

  // Per-way LRU ranks.
  lvs_rank_store u_ranks (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .ranks (ranks)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      victim_way         <= res.victim_way;
      checkpoint_request <= res.checkpoint_request;
      checkpoint_set     <= res.checkpoint_set;
      took_invalid       <= res.took_invalid;
    end
  end

endmodule

/* rtl/core/lvs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU victim select port checker
// Watches the top-level ports for result timing and result field consistency.
// ----------------------------------------------------------------------------
module lvs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           req_type,
  input logic [lvs_pkg::MASK_W-1:0]     valid_mask,
  input logic                           result_strobe,
  input logic                           checkpoint_request,
  input logic [lvs_pkg::SET_W-1:0]      checkpoint_set,
  input logic                           took_invalid
);
  import lvs_pkg::*;

  // A result appears only for a victim request that passed the request and result registers.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(start && !busy && req_type == REQ_VICTIM, 2))
    else $error("result without a matching victim request");

  // Every accepted victim request yields a result after the request and result registers.
  a_result_given: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_VICTIM) |=> ##1 result_strobe)
    else $error("victim request produced no result");

  // The checkpoint path never takes an invalid way.
  a_ckpt_excl: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && checkpoint_request) |-> !took_invalid)
    else $error("checkpoint and invalid-way result together");

  // The set index is reported only with a checkpoint.
  a_set_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !checkpoint_request) |-> checkpoint_set == '0)
    else $error("set index reported without a checkpoint");

  // An invalid way is taken only when the request showed one.
  a_invalid_seen: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && took_invalid) |-> $past(valid_mask != {MASK_W{1'b1}}, 2))
    else $error("invalid way taken with a full valid mask");

endmodule

bind lru_victim_select_dirty_threshold lvs_checker u_lvs_checker (
  .clk                (clk),
  .rst                (rst),
  .start              (start),
  .busy               (busy),
  .req_type           (req_type),
  .valid_mask         (valid_mask),
  .result_strobe      (result_strobe),
  .checkpoint_request (checkpoint_request),
  .checkpoint_set     (checkpoint_set),
  .took_invalid       (took_invalid)
);

/* test/lru_victim_select_dirty_threshold_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU victim select with dirty threshold: testbench
// Drives touch and victim requests through a bursty driver and checks every
// result against an in-bench true-LRU predictor. The run walks through several
// dirty thresholds and set ids, with the rank order carried across phases.
// ----------------------------------------------------------------------------
module lru_victim_select_dirty_threshold_tb;
  import lvs_pkg::*;

  // One request as it goes onto the request ports.
  typedef struct packed {
    req_kind_t         kind;
    logic [TOUCH_W-1:0] touch_way;
    logic [MASK_W-1:0]  valid;
    logic [MASK_W-1:0]  dirty;
    logic [MASK_W-1:0]  repl;
  } cache_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 req_type = 1'b0;
  logic [TOUCH_W-1:0]   touch_way = '0;
  logic [MASK_W-1:0]    valid_mask = '0;
  logic [MASK_W-1:0]    dirty_mask = '0;
  logic [MASK_W-1:0]    replaceable_mask = '0;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [SET_W-1:0]     cfg_wdata = '0;
  logic                 result_strobe;
  logic [OUT_WAY_W-1:0] victim_way;
  logic                 checkpoint_request;
  logic [SET_W-1:0]     checkpoint_set;
  logic                 took_invalid;

  lru_victim_select_dirty_threshold dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .req_type           (req_type),
    .touch_way          (touch_way),
    .valid_mask         (valid_mask),
    .dirty_mask         (dirty_mask),
    .replaceable_mask   (replaceable_mask),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .result_strobe      (result_strobe),
    .victim_way         (victim_way),
    .checkpoint_request (checkpoint_request),
    .checkpoint_set     (checkpoint_set),
    .took_invalid       (took_invalid)
  );

  // Requests waiting for the driver, and victim choices waiting for the DUT.
  cache_req_t pending_reqs[$];
  result_t    victim_choices[$];

  // Predictor state: rank per way and the mirrored registers.
  rank_t            lru_rank[WAYS];
  logic [THR_W-1:0] thr_mirror;
  logic [SET_W-1:0] set_mirror;

  int unsigned n_errors = 0;
  int unsigned n_touch = 0;
  int unsigned n_fill = 0;
  int unsigned n_checkpoint = 0;
  int unsigned n_lru_pick = 0;
  int unsigned n_way0_fallback = 0;
  int unsigned n_results = 0;

  // Driver pacing.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  drain_hold = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // A hung DUT ends the run here.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (n_errors < 50) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    n_errors++;
  endtask

  // Move one way to most recently used; younger ways age by one.
  function automatic void promote_way(input int unsigned w);
    rank_t r;
    r = lru_rank[w];
    for (int j = 0; j < WAYS; j++) begin
      if (lru_rank[j] < r) begin
        lru_rank[j] = lru_rank[j] + 1'b1;
      end
    end
    lru_rank[w] = '0;
  endfunction

  // Apply one accepted request to the predictor and queue the victim choice of a victim request.
  task automatic predict_victim(input cache_req_t rq);
    int unsigned first_invalid;
    int unsigned best;
    int unsigned dirty_cnt;
    rank_t       best_rank;
    result_t     res;
    if (rq.kind == REQ_TOUCH) begin
      promote_way(rq.touch_way);
      n_touch++;
    end else begin
      first_invalid = WAYS;
      best = 0;
      best_rank = '0;
      dirty_cnt = 0;
      for (int i = 0; i < WAYS; i++) begin
        if (first_invalid == WAYS && !rq.valid[i]) begin
          first_invalid = i;
        end
        if (lru_rank[i] > best_rank && rq.repl[i]) begin
          best = i;
          best_rank = lru_rank[i];
        end
        if (rq.dirty[i]) begin
          dirty_cnt++;
        end
      end
      res = '0;
      if (first_invalid < WAYS) begin
        // An empty way always wins and becomes MRU.
        res.victim_way = OUT_WAY_W'(first_invalid);
        res.took_invalid = 1'b1;
        promote_way(first_invalid);
        n_fill++;
      end else if (dirty_cnt >= thr_mirror) begin
        // Checkpoint path: the LRU way is reported and the order is kept.
        for (int i = 0; i < WAYS; i++) begin
          if (lru_rank[i] == rank_t'(WAYS - 1)) begin
            res.victim_way = OUT_WAY_W'(i);
          end
        end
        res.checkpoint_request = 1'b1;
        res.checkpoint_set = set_mirror;
        n_checkpoint++;
      end else begin
        // Oldest replaceable way, or way 0 when nothing qualifies.
        res.victim_way = OUT_WAY_W'(best);
        promote_way(best);
        if (best_rank == '0) begin
          n_way0_fallback++;
        end else begin
          n_lru_pick++;
        end
      end
      victim_choices.push_back(res);
    end
  endtask

  // Driver: bursts of requests with random gaps, now and then holding off
  // until every outstanding victim choice has come back.
  always @(posedge clk) begin : drive_requests
    logic next_start;
    next_start = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        predict_victim(pending_reqs.pop_front());
      end
      if (gap_left != 0) begin
        gap_left--;
      end else if (drain_hold) begin
        if (victim_choices.size() == 0) begin
          drain_hold = 1'b0;
        end
      end else if (pending_reqs.size() != 0) begin
        next_start = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          drain_hold = ($urandom_range(0, 9) == 0);
        end
      end
    end
    start <= next_start;
    if (next_start) begin
      req_type         <= pending_reqs[0].kind;
      touch_way        <= pending_reqs[0].touch_way;
      valid_mask       <= pending_reqs[0].valid;
      dirty_mask       <= pending_reqs[0].dirty;
      replaceable_mask <= pending_reqs[0].repl;
    end
  end

  // Monitor: every strobed result must match the oldest victim choice.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_strobe) begin
      n_results++;
      if (victim_choices.size() == 0) begin
        report_mismatch($sformatf("unexpected result, way %0d", victim_way));
      end else begin
        want = victim_choices.pop_front();
        if (victim_way !== want.victim_way) begin
          report_mismatch($sformatf("victim_way %0d, expected %0d",
                                    victim_way, want.victim_way));
        end
        if (checkpoint_request !== want.checkpoint_request) begin
          report_mismatch($sformatf("checkpoint_request %0b, expected %0b",
                                    checkpoint_request, want.checkpoint_request));
        end
        if (checkpoint_set !== want.checkpoint_set) begin
          report_mismatch($sformatf("checkpoint_set %0d, expected %0d",
                                    checkpoint_set, want.checkpoint_set));
        end
        if (took_invalid !== want.took_invalid) begin
          report_mismatch($sformatf("took_invalid %0b, expected %0b",
                                    took_invalid, want.took_invalid));
        end
      end
    end
  end

  task automatic push_request(input req_kind_t kind, input int unsigned way,
                              input logic [MASK_W-1:0] valid,
                              input logic [MASK_W-1:0] dirty,
                              input logic [MASK_W-1:0] repl);
    cache_req_t rq;
    rq.kind = kind;
    rq.touch_way = TOUCH_W'(way);
    rq.valid = valid;
    rq.dirty = dirty;
    rq.repl = repl;
    pending_reqs.push_back(rq);
  endtask

  // A mask with exactly n bits set at random places.
  function automatic logic [MASK_W-1:0] mask_with_count(input int unsigned n);
    logic [MASK_W-1:0] m;
    m = '0;
    while ($countones(m) < n) begin
      m[$urandom_range(0, MASK_W - 1)] = 1'b1;
    end
    return m;
  endfunction

  // Random requests: mostly all-valid victim requests so that the rank order
  // and the threshold compare get exercised, the rest touches and fills.
  task automatic push_random(input int unsigned count);
    logic [MASK_W-1:0] valid;
    logic [MASK_W-1:0] repl;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0:       valid = MASK_W'($urandom);
        1:       valid = ~(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
        default: valid = '1;
      endcase
      case ($urandom_range(0, 7))
        0:       repl = '0;
        1:       repl = '1;
        2:       repl = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        default: repl = MASK_W'($urandom);
      endcase
      push_request(($urandom_range(0, 99) < 35) ? REQ_TOUCH : REQ_VICTIM,
                   $urandom_range(0, WAYS - 1), valid,
                   mask_with_count($urandom_range(0, MASK_W)), repl);
    end
  endtask

  // Let the driver empty its queue and the DUT return every choice, then
  // wait for a trailing touch to settle the ranks.
  task automatic drain_requests();
    int unsigned waited;
    waited = 0;
    while (pending_reqs.size() != 0) begin
      @(posedge clk);
    end
    while (victim_choices.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(input cfg_idx_t idx, input logic [SET_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_DIRTY_THRESHOLD) begin
      thr_mirror = data[THR_W-1:0];
    end else begin
      set_mirror = data;
    end
  endtask

  // Stimulus: directed requests at the reset settings, then random phases.
  initial begin : stimulus
    int unsigned thr_plan[9];
    int unsigned set_plan[9];
    for (int i = 0; i < WAYS; i++) begin
      lru_rank[i] = rank_t'(i);
    end
    thr_mirror = THR_RESET;
    set_mirror = SET_RESET;
    thr_plan = '{0, 8, 15, 1, 7, 4, 3, 6, 5};
    set_plan = '{1023, 0, 682, 341, 1, 0, 0, 0, 0};
    for (int p = 5; p < 9; p++) begin
      set_plan[p] = $urandom_range(0, 1023);
    end

    // Fills: everything invalid, then the highest way and way 1 empty.
    push_request(REQ_VICTIM, 0, 8'h00, 8'h00, 8'hFF);
    push_request(REQ_VICTIM, 0, 8'h7F, 8'hFF, 8'h00);
    push_request(REQ_VICTIM, 0, 8'hFD, 8'h00, 8'hFF);
    // Touch every way in turn.
    for (int w = 0; w < WAYS; w++) begin
      push_request(REQ_TOUCH, w, 8'hFF, 8'hFF, 8'hFF);
    end
    // All dirty at the full threshold takes the checkpoint path.
    push_request(REQ_VICTIM, 0, 8'hFF, 8'hFF, 8'hFF);
    // One short of the threshold falls back to the oldest replaceable way.
    push_request(REQ_VICTIM, 0, 8'hFF, 8'h7F, 8'hFF);
    // Nothing replaceable picks way 0.
    push_request(REQ_VICTIM, 0, 8'hFF, 8'h00, 8'h00);
    // Only the MRU way replaceable also picks way 0.
    push_request(REQ_TOUCH, 3, 8'h00, 8'h00, 8'h00);
    push_request(REQ_VICTIM, 0, 8'hFF, 8'h80, 8'h08);
    push_request(REQ_VICTIM, 0, 8'hFF, 8'hAA, 8'h80);
    push_request(REQ_VICTIM, 0, 8'hFF, 8'h55, 8'h01);
    push_request(REQ_VICTIM, 0, 8'hFF, 8'hFE, 8'h55);
    push_request(REQ_TOUCH, 7, 8'hFF, 8'hFF, 8'hFF);
    push_random(40);

    while (rst) begin
      @(posedge clk);
    end

    // Each phase retunes both registers with the DUT idle.
    for (int p = 0; p < 9; p++) begin
      drain_requests();
      write_config(CFG_DIRTY_THRESHOLD,
                   {SET_W'($urandom) >> THR_W << THR_W} | SET_W'(thr_plan[p]));
      write_config(CFG_SET_ID, SET_W'(set_plan[p]));
      push_random(55);
    end

    drain_requests();
    while (victim_choices.size() != 0) begin
      report_mismatch($sformatf("missing result, expected way %0d",
                                victim_choices[0].victim_way));
      void'(victim_choices.pop_front());
    end

    $display("Run covered %0d touches and %0d victim results over 10 register settings.",
             n_touch, n_results);
    $display("Victims: %0d fills, %0d checkpoints, %0d LRU picks, %0d way-0 fallbacks.",
             n_fill, n_checkpoint, n_lru_pick, n_way0_fallback);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
